FILE: design/assert_macros.svh
// Assertion macros shared by the checker module of the frame field extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFX_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SFX_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sfx_pkg.sv
// Shared types, codes and helper functions of the response frame field extractor.
`default_nettype none

package sfx_pkg;

  localparam int MAX_FIELDS  = 8;
  localparam int FIELD_IDX_W = 3;
  localparam int FCNT_W      = 4;
  localparam int BCNT_W      = 9;
  localparam int DATA_W      = 32;
  localparam int TYPES_W     = 24;
  localparam int CFG_AW      = 5;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [BCNT_W-1:0] BCNT_MAX = 9'd511;

  // Input operation codes.
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_NEW  = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // Result kinds and status codes.
  localparam logic       KIND_VALUE    = 1'b0;
  localparam logic       KIND_STATUS   = 1'b1;
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TIMEOUT    = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_LAYOUT     = 2'd3;

  // Field type codes; the signed 8- and 16-bit types need sign extension.
  localparam logic [2:0] T_U8  = 3'd0;
  localparam logic [2:0] T_S8  = 3'd1;
  localparam logic [2:0] T_U16 = 3'd2;
  localparam logic [2:0] T_S16 = 3'd3;
  localparam logic [2:0] T_U24 = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FRAMED   = 3'd0;
  localparam logic [2:0] REG_FCOUNT   = 3'd1;
  localparam logic [2:0] REG_FTYPES   = 3'd2;
  localparam logic [2:0] REG_FREV     = 3'd3;
  localparam logic [2:0] REG_CHECK    = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RECV,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic               framed_mode;
    logic [FCNT_W-1:0]  field_count;
    logic [TYPES_W-1:0] field_types;
    logic [7:0]         field_reversed;
    logic               check_layout;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic                   kind;
    logic [FIELD_IDX_W-1:0] field_index;
    logic [DATA_W-1:0]      field_value;
    logic [1:0]             status;
    logic                   last;
  } out_word_t;

  // One completed run handed from the front to the back, with a snapshot
  // of the field values so the front may start the next frame at once.
  typedef struct packed {
    logic                                has_fields;
    logic [FCNT_W-1:0]                   nf;
    logic [1:0]                          status;
    logic [MAX_FIELDS-1:0][DATA_W-1:0]   values;
  } job_t;

  function automatic logic [2:0] size_of(input logic [2:0] t);
    logic [2:0] sz;
    unique case (t)
      T_U8, T_S8:   sz = 3'd1;
      T_U16, T_S16: sz = 3'd2;
      T_U24:        sz = 3'd3;
      default:      sz = 3'd4;
    endcase
    return sz;
  endfunction

  function automatic logic [2:0] type_of(input logic [TYPES_W-1:0] types,
                                         input logic [FIELD_IDX_W-1:0] i);
    return types[3*int'(i) +: 3];
  endfunction

endpackage

`default_nettype wire

FILE: design/serial_response_frame_field_extractor_core.sv
// Top level of the serial response frame field extractor.
//
// Input words carry one operation each: a received response byte, the start
// of a new request (clears the frame) or the end of the receive window. A
// word is taken at any rising edge with push high and full low; the front
// end handles one word per clock, and full rises whenever the job queue holds
// two runs: when the result side stalls, or when short runs pile up behind
// one that is still being expanded into value words.
// Result words come out through a queue-style port: while empty is low the
// oldest word sits on out_data and is taken on a rising edge with pop high.
// A frame that completes with the layout check enabled and met yields one value
// word per configured field and a final status word with last set; any other
// completed frame, and a window end, yields a single status word. With the back
// end idle, the job that finishes a run passes through the job queue into the
// output register, and further words follow one per clock while pop stays
// high. A stalled receiver holds the current word steady; the front keeps
// taking bytes until the job queue fills, since each job carries its own
// copy of the field values.
// The user must write configuration through the APB-style port only while idle;
// the block does not enforce it. Reset (synchronous, rst_n low) empties the queue
// and the output register, clears the frame state and loads the register defaults.
`default_nettype none

module serial_response_frame_field_extractor_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input channel
  input  wire logic               push,
  output logic                    full,
  input  wire sfx_pkg::in_word_t  in_data,
  // Result channel
  output logic                    empty,
  input  wire logic               pop,
  output sfx_pkg::out_word_t      out_data,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);
  import sfx_pkg::*;

  cfg_t  cfg;
  job_t  fjob;
  job_t  qjob;
  logic  fjob_valid;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  in_accept;

  // The front end never produces more than one job per accepted word, so
  // stopping input while the queue is full is enough to never lose a job.
  assign full      = q_full;
  assign in_accept = push && !q_full;

  sfx_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (in_accept),
    .in_word   (in_data),
    .job_valid (fjob_valid),
    .job       (fjob)
  );

  sfx_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fjob_valid),
    .wr_data (fjob),
    .rd_en   (q_pop),
    .rd_data (qjob),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The sequencer works straight off the queue head and retires the job
  // when it issues the closing status word.
  sfx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (qjob),
    .job_done  (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: design/sfx_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module sfx_regs (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output sfx_pkg::cfg_t           cfg
);
  import sfx_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FRAMED: cfg_nxt.framed_mode    = pwdata[0];
        REG_FCOUNT: cfg_nxt.field_count    = pwdata[FCNT_W-1:0];
        REG_FTYPES: cfg_nxt.field_types    = pwdata[TYPES_W-1:0];
        REG_FREV:   cfg_nxt.field_reversed = pwdata[7:0];
        REG_CHECK:  cfg_nxt.check_layout   = pwdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAMED: prdata = {31'b0, cfg_r.framed_mode};
      REG_FCOUNT: prdata = {{(32-FCNT_W){1'b0}}, cfg_r.field_count};
      REG_FTYPES: prdata = {{(32-TYPES_W){1'b0}}, cfg_r.field_types};
      REG_FREV:   prdata = {24'b0, cfg_r.field_reversed};
      REG_CHECK:  prdata = {31'b0, cfg_r.check_layout};
      default:    prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.framed_mode    <= 1'b1;
      cfg_r.field_count    <= '0;
      cfg_r.field_types    <= '0;
      cfg_r.field_reversed <= '0;
      cfg_r.check_layout   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/sfx_front.sv
// Front end: frame tracking, checksum, field assembly and run classification.
`default_nettype none

module sfx_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sfx_pkg::cfg_t     cfg,
  input  wire logic              accept,
  input  wire sfx_pkg::in_word_t in_word,
  output logic                   job_valid,
  output sfx_pkg::job_t          job
);
  import sfx_pkg::*;

  phase_t                            phase_r, phase_nxt;
  logic [BCNT_W-1:0]                 bcnt_r, bcnt_nxt;
  logic [7:0]                        len_r, len_nxt;
  logic [7:0]                        sum_r, sum_nxt;
  logic [FCNT_W-1:0]                 cur_r, cur_nxt;
  logic [1:0]                        bif_r, bif_nxt;
  logic [DATA_W-1:0]                 acc_r, acc_nxt;
  logic [MAX_FIELDS-1:0][DATA_W-1:0] store_r, store_nxt;

  logic [FCNT_W-1:0] nf;
  logic [5:0]        total;
  logic [2:0]        ftype;
  logic [2:0]        fsize;
  logic [2:0]        bif_inc;
  logic [DATA_W-1:0] acc_new;
  logic [DATA_W-1:0] fval;
  logic [7:0]        b;
  logic              complete;

  assign b = in_word.rx_byte;

  // Fields in use and the payload size they add up to.
  always_comb begin
    nf = (cfg.field_count > FCNT_W'(MAX_FIELDS)) ? FCNT_W'(MAX_FIELDS) : cfg.field_count;
    total = '0;
    for (int i = 0; i < MAX_FIELDS; i++) begin
      if (FCNT_W'(i) < nf) begin
        total = total + {3'b0, size_of(type_of(cfg.field_types, FIELD_IDX_W'(i)))};
      end
    end
  end

  // Next piece of the field being assembled.
  always_comb begin
    ftype   = type_of(cfg.field_types, cur_r[FIELD_IDX_W-1:0]);
    fsize   = size_of(ftype);
    bif_inc = {1'b0, bif_r} + 3'd1;
    if (cfg.field_reversed[cur_r[FIELD_IDX_W-1:0]]) begin
      acc_new = {acc_r[DATA_W-9:0], b};
    end else begin
      acc_new = acc_r | ({24'b0, b} << {bif_r, 3'b000});
    end
    fval = acc_new;
    if (ftype == T_S8 && fval[7]) begin
      fval[31:8] = '1;
    end
    if (ftype == T_S16 && fval[15]) begin
      fval[31:16] = '1;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    bcnt_nxt  = bcnt_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    cur_nxt   = cur_r;
    bif_nxt   = bif_r;
    acc_nxt   = acc_r;
    store_nxt = store_r;
    job_valid = 1'b0;
    job       = '0;
    complete  = 1'b0;
    if (accept) begin
      unique case (in_word.op)
        OP_NEW: begin
          phase_nxt = PH_IDLE;
          bcnt_nxt  = '0;
          len_nxt   = '0;
          sum_nxt   = '0;
          cur_nxt   = '0;
          bif_nxt   = '0;
          acc_nxt   = '0;
        end
        OP_END: begin
          if (phase_r != PH_DONE) begin
            phase_nxt  = PH_DONE;
            job_valid  = 1'b1;
            if (bcnt_r == '0) begin
              job.status = ST_TIMEOUT;
            end else begin
              job.status = cfg.framed_mode ? ST_INCOMPLETE : ST_OK;
            end
          end
        end
        OP_BYTE: begin
          if (phase_r != PH_DONE) begin
            phase_nxt = PH_RECV;
            if (bcnt_r != BCNT_MAX) begin
              bcnt_nxt = bcnt_r + 9'd1;
            end
            if (bcnt_r != '0) begin
              sum_nxt = sum_r + b;
            end
            if (bcnt_r == 9'd3) begin
              len_nxt = b;
            end
            if (bcnt_r >= 9'd4 && bcnt_r != BCNT_MAX && cur_r < nf) begin
              if (bif_inc >= fsize) begin
                store_nxt[cur_r[FIELD_IDX_W-1:0]] = fval;
                cur_nxt = cur_r + 4'd1;
                bif_nxt = '0;
                acc_nxt = '0;
              end else begin
                bif_nxt = bif_inc[1:0];
                acc_nxt = acc_new;
              end
            end
            complete = cfg.framed_mode && (bcnt_nxt > 9'd3) &&
                       ({1'b0, bcnt_nxt} == ({2'b0, len_nxt} + 10'd5)) &&
                       (sum_nxt == 8'd0);
            if (complete) begin
              phase_nxt = PH_DONE;
              job_valid = 1'b1;
              if (!cfg.check_layout) begin
                job.status = ST_OK;
              end else if (({3'b0, total} + 9'd5) != bcnt_nxt) begin
                job.status = ST_LAYOUT;
              end else begin
                job.status     = ST_OK;
                job.has_fields = 1'b1;
                job.nf         = nf;
                job.values     = store_nxt;
              end
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bcnt_r  <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      cur_r   <= '0;
      bif_r   <= '0;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      cur_r   <= cur_nxt;
      bif_r   <= bif_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Field store has no reset; an entry holds garbage until first written.
  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule

`default_nettype wire

FILE: design/sfx_queue.sv
// Short job queue between the front end and the result sequencer.
`default_nettype none

module sfx_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire sfx_pkg::job_t wr_data,
  input  wire logic          rd_en,
  output sfx_pkg::job_t      rd_data,
  output logic               full,
  output logic               empty
);
  import sfx_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rp_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH-1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH-1)) ? '0 : rp_r + QPTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/sfx_back.sv
// Result sequencer: expands the job at the queue head into result words.
`default_nettype none

module sfx_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  input  wire sfx_pkg::job_t job,
  output logic               job_done,
  input  wire logic          pop,
  output logic               empty,
  output sfx_pkg::out_word_t out_data
);
  import sfx_pkg::*;

  logic [FCNT_W-1:0] idx_r, idx_nxt;
  logic              ovalid_r, ovalid_nxt;
  out_word_t         oword_r, oword_nxt;
  logic              advance;
  logic              is_value;

  assign empty    = !ovalid_r;
  assign out_data = oword_r;
  assign advance  = !ovalid_r || pop;
  assign is_value = job.has_fields && (idx_r < job.nf);

  always_comb begin
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    oword_nxt  = oword_r;
    job_done   = 1'b0;
    if (advance) begin
      ovalid_nxt = job_valid;
      if (job_valid) begin
        oword_nxt = '0;
        if (is_value) begin
          oword_nxt.kind        = KIND_VALUE;
          oword_nxt.field_index = idx_r[FIELD_IDX_W-1:0];
          oword_nxt.field_value = job.values[idx_r[FIELD_IDX_W-1:0]];
          idx_nxt               = idx_r + 4'd1;
        end else begin
          oword_nxt.kind   = KIND_STATUS;
          oword_nxt.status = job.status;
          oword_nxt.last   = 1'b1;
          idx_nxt          = '0;
          job_done         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oword_r <= oword_nxt;
  end

endmodule

`default_nettype wire

FILE: design/sfx_checker.sv
// Port-level checker for the frame field extractor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module sfx_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               push,
  input wire logic               full,
  input wire sfx_pkg::in_word_t  in_data,
  input wire logic               empty,
  input wire logic               pop,
  input wire sfx_pkg::out_word_t out_data
);
  import sfx_pkg::*;

  // Reset leaves both channels idle: nothing to read, room to write.
  `SFX_ASSERT_NXT(a_reset_idle, clk, 1'b1, !rst_n, empty && !full, "channels not idle after reset")

  // A waiting result word holds while the receiver stalls.
  `SFX_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_data), "result word changed while stalled")

  // A value word is always followed at once by the rest of its run.
  `SFX_ASSERT_NXT(a_run_cont, clk, rst_n, !empty && pop && out_data.kind == KIND_VALUE, !empty, "run broken after a value word")

  // Within a run the field index steps by one until the status word.
  `SFX_ASSERT_NXT(a_idx_step, clk, rst_n, !empty && pop && out_data.kind == KIND_VALUE, (out_data.kind == KIND_STATUS) || (out_data.field_index == $past(out_data.field_index) + 3'd1), "field index out of order")

  // Only status words close a run.
  `SFX_ASSERT_IMP(a_last_status, clk, rst_n, !empty && out_data.last, out_data.kind == KIND_STATUS, "last set on a value word")

endmodule

bind serial_response_frame_field_extractor_core sfx_checker u_sfx_checker (.*);

`default_nettype wire
